@@ rtl/migc_pkg.sv @@
package migc_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 12;
  localparam int RAD_CFG_W = 3;

  // gray = floor(sum / 3) as floor(sum * 683 / 2048), exact for sum < 2048
  localparam int SUM_W = 10;
  localparam int GRAY_MUL = 683;
  localparam int GRAY_SHIFT = 11;
  localparam int PROD_W = 20;

  localparam logic [CFG_W-1:0] COLUMNS_RST = 12'd640;
  localparam logic [CFG_W-1:0] ROWS_RST = 12'd480;
  localparam logic [RAD_CFG_W-1:0] RADIUS_RST = 3'd1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_RADIUS  = 2'd2
  } cfg_idx_t;

endpackage

@@ rtl/morph_inner_gradient_edge_core.sv @@
// Inner morphological gradient with a cross element over a raster RGB stream.
//
// Input beats carry one pixel (in_func = 0) or a drain tick (in_func = 1).
// Each pixel is turned into gray (r+g+b)/3. For pixel p the block returns
// gray[p] minus the minimum over p, p+-k and p+-k*columns (k = 1..radius);
// taps outside the frame are skipped. The result for pixel p is caused by
// input item p + radius*columns + radius, so drain ticks flush the frame end.
// out_frame_last marks the frame's final result; the next item starts a frame.
//
// Throughput: one item per clock while in_stall is low. An item passes stages
// 1, 2 and 3 before its result reaches the output register. The state is one
// memory of MAX_COLUMNS words, each the column history of 2*MAX_RADIUS+1
// gray values; every item reads its column word and writes it back from
// stage 1, with forwarding when consecutive items hit the same column.
// Reset clears counters and restores default registers; the memory is not
// cleared. in_stall is high for one cycle after reset and after each register
// write. When out_stall holds a result, the whole pipeline and input hold.
module morph_inner_gradient_edge_core
  import migc_pkg::*;
#(
  parameter int MAX_COLUMNS = 2048,
  parameter int MAX_RADIUS  = 4,
  parameter int MAX_ROWS    = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_func,
  input  pix_t                 in_red_in,
  input  pix_t                 in_green_in,
  input  pix_t                 in_blue_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pix_t                 out_edge_value,
  output logic                 out_frame_last
);

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int CNW = $clog2(MAX_COLUMNS + 1);
  localparam int RNW = $clog2(MAX_ROWS + 1);
  localparam int RW  = $clog2(MAX_RADIUS + 1);
  localparam int WN  = 2 * MAX_RADIUS + 1;
  localparam int HN  = 2 * MAX_RADIUS;
  localparam int HIW = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1;
  localparam int EW  = $clog2(WN);

  // frame size, position arithmetic and item counter widths
  localparam int NW = RNW + CNW;
  localparam int AW = NW + 1;
  localparam int TW = AW;

  typedef logic [WN-1:0][PIX_W-1:0] word_t;

  // configuration
  logic [CFG_W-1:0]     cfg_cols_r, cfg_rows_r;
  logic [RAD_CFG_W-1:0] cfg_rad_r;
  logic                 cfg_pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cols_r <= COLUMNS_RST;
      cfg_rows_r <= ROWS_RST;
      cfg_rad_r  <= RADIUS_RST;
      cfg_pend_r <= 1'b1;
    end else begin
      cfg_pend_r <= cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          CFG_COLUMNS: cfg_cols_r <= cfg_data;
          CFG_ROWS:    cfg_rows_r <= cfg_data;
          CFG_RADIUS:  cfg_rad_r  <= cfg_data[RAD_CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // clamped and derived frame geometry
  logic [CNW-1:0]     cols_c, cols_r;
  logic [RNW-1:0]     rows_c;
  logic [RW-1:0]      rad_c, rad_r;
  logic [RNW+CNW-1:0] n_prod;
  logic [NW-1:0]      n_r;
  logic [AW-1:0]      lag_r;
  logic [AW-1:0]      kc_r [MAX_RADIUS];

  always_comb begin
    if (cfg_cols_r == '0) cols_c = CNW'(1);
    else if (int'(cfg_cols_r) > MAX_COLUMNS) cols_c = CNW'(MAX_COLUMNS);
    else cols_c = CNW'(cfg_cols_r);
    if (cfg_rows_r == '0) rows_c = RNW'(1);
    else if (int'(cfg_rows_r) > MAX_ROWS) rows_c = RNW'(MAX_ROWS);
    else rows_c = RNW'(cfg_rows_r);
    if (cfg_rad_r == '0) rad_c = RW'(1);
    else if (int'(cfg_rad_r) > MAX_RADIUS) rad_c = RW'(MAX_RADIUS);
    else rad_c = RW'(cfg_rad_r);
  end

  assign n_prod = rows_c * cols_c;

  always_ff @(posedge clk) begin
    cols_r <= cols_c;
    rad_r  <= rad_c;
    n_r    <= NW'(n_prod);
    lag_r  <= AW'(cols_c) * AW'(rad_c) + AW'(rad_c);
    for (int k = 0; k < MAX_RADIUS; k++) begin
      kc_r[k] <= AW'(int'(cols_c) * (k + 1));
    end
  end

  // handshake
  logic en, acc;
  logic out_v_r, out_last_r;

  assign out_valid = out_v_r;
  assign en        = !out_v_r || !out_stall;
  assign in_stall  = !en || cfg_pend_r;
  assign acc       = in_valid && !in_stall;

  // item position and tap masks
  logic [TW-1:0]         t_r;
  logic [CW-1:0]         slot_r;
  logic [AW-1:0]         t_ext, p, n_ext;
  logic                  past_lag, emit, wrap, last;
  logic [MAX_RADIUS-1:0] hlo, hhi, vlo, vhi;
  pix_t                  gray;

  assign t_ext    = AW'(t_r);
  assign n_ext    = AW'(n_r);
  assign past_lag = t_ext >= lag_r;
  assign p        = t_ext - lag_r;
  assign emit     = past_lag && (p < n_ext);
  assign wrap     = past_lag && (p >= n_ext - AW'(1));
  assign last     = p == n_ext - AW'(1);

  always_comb begin
    for (int k = 0; k < MAX_RADIUS; k++) begin
      hlo[k] = (k < int'(rad_r)) && (p >= AW'(k + 1));
      hhi[k] = (k < int'(rad_r)) && (p + AW'(k + 1) < n_ext);
      vlo[k] = (k < int'(rad_r)) && (p >= kc_r[k]);
      vhi[k] = (k < int'(rad_r)) && (p + kc_r[k] < n_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r    <= '0;
      slot_r <= '0;
    end else if (acc) begin
      if (wrap) begin
        t_r    <= '0;
        slot_r <= '0;
      end else begin
        t_r <= t_r + TW'(1);
        if (CNW'(slot_r) + CNW'(1) >= cols_r) slot_r <= '0;
        else slot_r <= slot_r + CW'(1);
      end
    end
  end

  migc_gray u_gray (
    .red   (in_red_in),
    .green (in_green_in),
    .blue  (in_blue_in),
    .gray  (gray)
  );

  // column history memory
  word_t mem [MAX_COLUMNS];
  word_t rd_q;
  word_t w_word, wfwd_r, base;

  // stage 1: read data back, shift in gray, write back
  logic                  s1_v_r, fwd_r, s1_emit_r, s1_last_r;
  logic [CW-1:0]         s1_slot_r;
  pix_t                  s1_gray_r;
  logic [MAX_RADIUS-1:0] s1_hlo_r, s1_hhi_r, s1_vlo_r, s1_vhi_r;

  always_ff @(posedge clk) begin
    if (acc) rd_q <= mem[slot_r];
    if (s1_v_r && en) mem[s1_slot_r] <= w_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else if (en) begin
      s1_v_r <= acc;
      fwd_r  <= acc && s1_v_r && (s1_slot_r == slot_r);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_slot_r <= slot_r;
      s1_gray_r <= in_func ? '0 : gray;
      s1_emit_r <= emit;
      s1_last_r <= last;
      s1_hlo_r  <= hlo;
      s1_hhi_r  <= hhi;
      s1_vlo_r  <= vlo;
      s1_vhi_r  <= vhi;
    end
  end

  assign base = fwd_r ? wfwd_r : rd_q;

  always_comb begin
    w_word[0] = s1_gray_r;
    for (int j = 1; j < WN; j++) begin
      w_word[j] = base[j-1];
    end
  end

  // item history: column words and the horizontal row of the center line
  word_t hist_r [MAX_RADIUS];
  pix_t  hh_r [HN];
  word_t vword;
  pix_t  hrow [WN];

  always_ff @(posedge clk) begin
    if (s1_v_r && en) begin
      wfwd_r    <= w_word;
      hist_r[0] <= w_word;
      for (int i = 1; i < MAX_RADIUS; i++) hist_r[i] <= hist_r[i-1];
      hh_r[0] <= w_word[EW'(rad_r)];
      for (int i = 1; i < HN; i++) hh_r[i] <= hh_r[i-1];
    end
  end

  assign vword = hist_r[HIW'(rad_r - RW'(1))];

  always_comb begin
    hrow[0] = w_word[EW'(rad_r)];
    for (int i = 1; i < WN; i++) hrow[i] = hh_r[i-1];
  end

  // stage 2: gathered taps, masked taps read as full scale
  logic                  s2_v_r, s2_last_r;
  pix_t                  s2_center_r;
  pix_t                  s2_tap_r [MAX_RADIUS][4];

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r && s1_emit_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_last_r   <= s1_last_r;
      s2_center_r <= hrow[EW'(rad_r)];
      for (int k = 0; k < MAX_RADIUS; k++) begin
        s2_tap_r[k][0] <= s1_hlo_r[k] ? hrow[EW'(int'(rad_r) + k + 1)] : '1;
        s2_tap_r[k][1] <= s1_hhi_r[k] ? hrow[EW'(int'(rad_r) - k - 1)] : '1;
        s2_tap_r[k][2] <= s1_vlo_r[k] ? vword[EW'(int'(rad_r) + k + 1)] : '1;
        s2_tap_r[k][3] <= s1_vhi_r[k] ? vword[EW'(int'(rad_r) - k - 1)] : '1;
      end
    end
  end

  // stage 3: minimum per arm distance
  logic s3_v_r, s3_last_r;
  pix_t s3_center_r;
  pix_t s3_min_r [MAX_RADIUS];
  pix_t arm_min [MAX_RADIUS];

  always_comb begin
    for (int k = 0; k < MAX_RADIUS; k++) begin
      arm_min[k] = s2_tap_r[k][0];
      for (int j = 1; j < 4; j++) begin
        if (s2_tap_r[k][j] < arm_min[k]) arm_min[k] = s2_tap_r[k][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (en) s3_v_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_last_r   <= s2_last_r;
      s3_center_r <= s2_center_r;
      for (int k = 0; k < MAX_RADIUS; k++) s3_min_r[k] <= arm_min[k];
    end
  end

  // output register
  pix_t out_edge_r;
  pix_t cross_min;

  always_comb begin
    cross_min = s3_center_r;
    for (int k = 0; k < MAX_RADIUS; k++) begin
      if (s3_min_r[k] < cross_min) cross_min = s3_min_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= s3_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_edge_r <= s3_center_r - cross_min;
      out_last_r <= s3_last_r;
    end
  end

  assign out_edge_value = out_edge_r;
  assign out_frame_last = out_last_r;

  // checks
  a_reset_clears_count: assert property (@(posedge clk) !rst_n |=> t_r == '0)
    else $error("item count not cleared by reset");

  a_accept_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> s1_v_r)
    else $error("accepted beat missing from write-back stage");

  a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_v_r)
    else $error("forward select without an item in write-back stage");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !en) |=> (s1_v_r && $stable(s1_slot_r)))
    else $error("write-back stage changed while stalled");

endmodule

@@ rtl/migc_gray.sv @@
module migc_gray
  import migc_pkg::*;
(
  input  pix_t red,
  input  pix_t green,
  input  pix_t blue,
  output pix_t gray
);

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;

  assign sum  = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
  assign prod = PROD_W'(sum) * PROD_W'(GRAY_MUL);
  assign gray = prod[GRAY_SHIFT +: PIX_W];

endmodule
